// ----- rtl/ebc_pkg.sv -----
// Package with shared constants and types of the 8-bit execute unit.
package ebc_pkg;
    localparam int ADDR_BITS_DEF = 16;

    localparam logic [7:0] OP_HLT = 8'h76;
    localparam logic [7:0] OP_RNZ = 8'hC0;
    localparam logic [7:0] OP_POP_B = 8'hC1;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_EXEC = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OP,
        ST_IMM1,
        ST_IMM2,
        ST_DATA1,
        ST_DATA2,
        ST_WR2,
        ST_RDWAIT,
        ST_DONE
    } state_t;

    function automatic logic par_even(input logic [7:0] v);
        par_even = ~^v;
    endfunction
endpackage

// ----- rtl/eight_bit_cpu_execute_unit.sv -----
// Top level of the 8-bit execute unit: sequencer, register file and memory port.
// Each item runs through a sequencer around one single-port byte memory with a registered
// read. A load is written as it is accepted, and a read waits in ST_RDWAIT for its data.
// An instruction is accepted, then fetches its bytes in turn (opcode, immediates,
// operands), passes a further state when it stores two bytes, and finishes; a single store
// shares the cycle in which the instruction executes. The result is held in an output
// register, so the next item is accepted while it waits; an item only finishes once the
// previous result is taken.
module eight_bit_cpu_execute_unit #(
    parameter int ADDR_BITS = ebc_pkg::ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [15:0] m_program_counter,
    output logic [15:0] m_stack_pointer,
    output logic [7:0]  m_accumulator,
    output logic [4:0]  m_flags,
    output logic [15:0] m_pair_bc,
    output logic [15:0] m_pair_de,
    output logic [15:0] m_pair_hl
);
    localparam int DEPTH = 1 << ADDR_BITS;

    ebc_pkg::state_t state_reg, state_next;
    logic [1:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [7:0]  op_reg, imm1_reg;
    logic [7:0]  b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg;
    logic [15:0] pc_reg, sp_reg;
    logic        fs_reg, fz_reg, fac_reg, fp_reg, fcy_reg;
    logic [7:0]  rd_reg;

    logic        out_load;
    logic [7:0]  out_rd_reg, out_a_reg;
    logic [15:0] out_pc_reg, out_sp_reg, out_bc_reg, out_de_reg, out_hl_reg;
    logic [4:0]  out_fl_reg;

    logic        mem_we;
    logic [15:0] mem_a;
    logic [7:0]  mem_wd, mem_rd;

    ebc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_mem (
        .aclk(aclk), .we(mem_we), .addr(mem_a[ADDR_BITS-1:0]),
        .wdata(mem_wd), .rdata(mem_rd)
    );

    assign s_ready = (state_reg == ebc_pkg::ST_IDLE);
    assign out_load = (state_reg == ebc_pkg::ST_DONE) && (!m_valid || m_ready);

    // The opcode, the first immediate and the first operand are taken straight from the
    // memory in the cycle after their read and from their registers later on.
    logic [7:0] op_cur, imm8_cur, d1_byte;
    assign op_cur = (state_reg == ebc_pkg::ST_OP) ? mem_rd : op_reg;
    assign imm8_cur = (state_reg == ebc_pkg::ST_IMM1) ? mem_rd : imm1_reg;
    assign d1_byte = (state_reg == ebc_pkg::ST_DATA1) ? mem_rd : data_reg;

    logic [2:0] yy, zz;
    logic [1:0] pp;
    logic [15:0] hl, bc, de, imm16;
    assign yy = op_cur[5:3];
    assign zz = op_cur[2:0];
    assign pp = op_cur[5:4];
    assign hl = {h_reg, l_reg};
    assign bc = {b_reg, c_reg};
    assign de = {d_reg, e_reg};
    assign imm16 = {mem_rd, imm1_reg};

    function automatic logic [7:0] rsel(input logic [2:0] code, input logic [7:0] b,
        input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
        input logic [7:0] h, input logic [7:0] l, input logic [7:0] a,
        input logic [7:0] m);
        case (code)
            3'd0: rsel = b;
            3'd1: rsel = c;
            3'd2: rsel = d;
            3'd3: rsel = e;
            3'd4: rsel = h;
            3'd5: rsel = l;
            3'd6: rsel = m;
            default: rsel = a;
        endcase
    endfunction

    // Opcode classes.
    logic is_mov, is_alu, src_m, need_imm1, need_imm2, need_data1, need_data2;
    logic wr1, wr2;
    always_comb begin
        is_mov = (op_cur[7:6] == 2'b01) && (op_cur != ebc_pkg::OP_HLT);
        is_alu = (op_cur[7:6] == 2'b10);
        src_m = (is_mov || is_alu) && (zz == 3'd6);
        need_imm1 = 1'b0;
        need_imm2 = 1'b0;
        need_data1 = src_m;
        need_data2 = 1'b0;
        wr1 = is_mov && (yy == 3'd6);
        wr2 = 1'b0;
        if (op_cur == ebc_pkg::OP_RNZ) begin
            need_data1 = !fz_reg;
            need_data2 = !fz_reg;
        end else if (op_cur == ebc_pkg::OP_POP_B) begin
            need_data1 = 1'b1;
            need_data2 = 1'b1;
        end else if (op_cur[7:6] == 2'b00) begin
            case (zz)
                3'd1: begin
                    need_imm1 = !yy[0];
                    need_imm2 = !yy[0];
                end
                3'd2: begin
                    need_imm1 = yy[2];
                    need_imm2 = yy[2];
                    need_data1 = (yy == 3'd1) || (yy == 3'd3) || (yy == 3'd5) || (yy == 3'd7);
                    need_data2 = (yy == 3'd5);
                    wr1 = (yy == 3'd0) || (yy == 3'd2) || (yy == 3'd4) || (yy == 3'd6);
                    wr2 = (yy == 3'd4);
                end
                3'd4, 3'd5: begin
                    need_data1 = (yy == 3'd6);
                    wr1 = (yy == 3'd6);
                end
                3'd6: begin
                    need_imm1 = 1'b1;
                    wr1 = (yy == 3'd6);
                end
                default: ;
            endcase
        end
    end

    // Address of the first and second operand byte and of the first store.
    logic [15:0] d1_addr, d2_addr, w1_addr;
    logic [15:0] imm_base;
    always_comb begin
        d1_addr = hl;
        if (op_cur == ebc_pkg::OP_RNZ || op_cur == ebc_pkg::OP_POP_B) begin
            d1_addr = sp_reg;
        end else if (op_cur[7:6] == 2'b00 && zz == 3'd2) begin
            case (yy)
                3'd1: d1_addr = bc;
                3'd3: d1_addr = de;
                default: d1_addr = {addr_reg[15:8], imm1_reg};
            endcase
        end
        d2_addr = d1_addr + 16'd1;
        imm_base = {addr_reg[15:8], imm1_reg};
        w1_addr = hl;
        if (op_cur[7:6] == 2'b00 && zz == 3'd2) begin
            case (yy)
                3'd0: w1_addr = bc;
                3'd2: w1_addr = de;
                default: w1_addr = imm_base;
            endcase
        end
    end

    // Execution datapath.
    logic [7:0]  b_n, c_n, d_n, e_n, h_n, l_n, a_n, wdat1;
    logic [15:0] pc_n, sp_n;
    logic        fs_n, fz_n, fac_n, fp_n, fcy_n, szp_upd;
    logic [7:0]  res8, src, x, addb, v;
    logic [8:0]  sum9;
    logic [16:0] sum17;
    logic [15:0] rp, rp2;
    logic        cin;
    logic [7:0]  corr;
    logic [3:0]  lo4, hi4;
    always_comb begin
        b_n = b_reg; c_n = c_reg; d_n = d_reg; e_n = e_reg;
        h_n = h_reg; l_n = l_reg; a_n = a_reg;
        pc_n = pc_reg + 16'd1;
        sp_n = sp_reg;
        fs_n = fs_reg; fz_n = fz_reg; fac_n = fac_reg; fp_n = fp_reg; fcy_n = fcy_reg;
        szp_upd = 1'b0;
        res8 = 8'h00;
        wdat1 = a_reg;
        src = rsel(zz, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg, d1_byte);
        x = 8'h00; addb = 8'h00; cin = 1'b0; sum9 = 9'h000; sum17 = 17'h0;
        rp = 16'h0; rp2 = 16'h0; corr = 8'h00; v = 8'h00;
        lo4 = a_reg[3:0]; hi4 = a_reg[7:4];
        if (need_imm2) begin
            pc_n = pc_reg + 16'd3;
        end else if (need_imm1) begin
            pc_n = pc_reg + 16'd2;
        end
        if (is_mov) begin
            case (yy)
                3'd0: b_n = src;
                3'd1: c_n = src;
                3'd2: d_n = src;
                3'd3: e_n = src;
                3'd4: h_n = src;
                3'd5: l_n = src;
                3'd6: wdat1 = src;
                default: a_n = src;
            endcase
        end else if (is_alu) begin
            x = src;
            case (yy)
                3'd0, 3'd1: begin
                    addb = x;
                    cin = yy[0] & fcy_reg;
                end
                default: begin
                    addb = ~x;
                    cin = (yy == 3'd3) ? !fcy_reg : 1'b1;
                end
            endcase
            sum9 = {1'b0, a_reg} + {1'b0, addb} + {8'h00, cin};
            case (yy)
                3'd4: begin
                    res8 = a_reg & x; fcy_n = 1'b0; fac_n = a_reg[3] | x[3];
                end
                3'd5: begin
                    res8 = a_reg ^ x; fcy_n = 1'b0; fac_n = 1'b0;
                end
                3'd6: begin
                    res8 = a_reg | x; fcy_n = 1'b0; fac_n = 1'b0;
                end
                default: begin
                    res8 = sum9[7:0];
                    fac_n = a_reg[4] ^ addb[4] ^ sum9[4];
                    fcy_n = (yy[1] == 1'b0) ? sum9[8] : !sum9[8];
                end
            endcase
            szp_upd = 1'b1;
            if (yy != 3'd7) begin
                a_n = res8;
            end
        end else if (op_cur == ebc_pkg::OP_RNZ) begin
            if (!fz_reg) begin
                pc_n = {mem_rd, data_reg};
                sp_n = sp_reg + 16'd2;
            end
        end else if (op_cur == ebc_pkg::OP_POP_B) begin
            c_n = data_reg;
            b_n = mem_rd;
            sp_n = sp_reg + 16'd2;
        end else if (op_cur[7:6] == 2'b00) begin
            case (pp)
                2'd0: rp = bc;
                2'd1: rp = de;
                2'd2: rp = hl;
                default: rp = sp_reg;
            endcase
            case (zz)
                3'd1: begin
                    if (yy[0]) begin
                        sum17 = {1'b0, hl} + {1'b0, rp};
                        fcy_n = sum17[16];
                        h_n = sum17[15:8];
                        l_n = sum17[7:0];
                    end else begin
                        case (pp)
                            2'd0: {b_n, c_n} = imm16;
                            2'd1: {d_n, e_n} = imm16;
                            2'd2: {h_n, l_n} = imm16;
                            default: sp_n = imm16;
                        endcase
                    end
                end
                3'd2: begin
                    case (yy)
                        3'd1, 3'd3, 3'd7: a_n = d1_byte;
                        3'd4: wdat1 = l_reg;
                        3'd5: begin
                            l_n = data_reg;
                            h_n = mem_rd;
                        end
                        default: ;
                    endcase
                end
                3'd3: begin
                    rp2 = yy[0] ? rp - 16'd1 : rp + 16'd1;
                    case (pp)
                        2'd0: {b_n, c_n} = rp2;
                        2'd1: {d_n, e_n} = rp2;
                        2'd2: {h_n, l_n} = rp2;
                        default: sp_n = rp2;
                    endcase
                end
                3'd4, 3'd5, 3'd6: begin
                    v = rsel(yy, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg, d1_byte);
                    if (zz == 3'd4) begin
                        fac_n = (v[3:0] == 4'hF);
                        res8 = v + 8'd1;
                        szp_upd = 1'b1;
                    end else if (zz == 3'd5) begin
                        fac_n = (v[3:0] != 4'h0);
                        res8 = v - 8'd1;
                        szp_upd = 1'b1;
                    end else begin
                        res8 = imm8_cur;
                    end
                    case (yy)
                        3'd0: b_n = res8;
                        3'd1: c_n = res8;
                        3'd2: d_n = res8;
                        3'd3: e_n = res8;
                        3'd4: h_n = res8;
                        3'd5: l_n = res8;
                        3'd6: wdat1 = res8;
                        default: a_n = res8;
                    endcase
                end
                3'd7: begin
                    case (yy)
                        3'd0: begin
                            fcy_n = a_reg[7]; a_n = {a_reg[6:0], a_reg[7]};
                        end
                        3'd1: begin
                            fcy_n = a_reg[0]; a_n = {a_reg[0], a_reg[7:1]};
                        end
                        3'd2: begin
                            fcy_n = a_reg[7]; a_n = {a_reg[6:0], fcy_reg};
                        end
                        3'd3: begin
                            fcy_n = a_reg[0]; a_n = {fcy_reg, a_reg[7:1]};
                        end
                        3'd4: begin
                            if (lo4 > 4'd9 || fac_reg) begin
                                corr = corr + 8'h06;
                            end
                            if (hi4 > 4'd9 || fcy_reg || (hi4 >= 4'd9 && lo4 > 4'd9)) begin
                                corr = corr + 8'h60;
                                fcy_n = 1'b1;
                            end
                            sum9 = {1'b0, a_reg} + {1'b0, corr};
                            res8 = sum9[7:0];
                            fac_n = a_reg[4] ^ corr[4] ^ sum9[4];
                            szp_upd = 1'b1;
                            a_n = res8;
                        end
                        3'd5: a_n = ~a_reg;
                        3'd6: fcy_n = 1'b1;
                        default: fcy_n = !fcy_reg;
                    endcase
                end
                default: ;
            endcase
        end
        if (szp_upd) begin
            fs_n = res8[7];
            fz_n = (res8 == 8'h00);
            fp_n = ebc_pkg::par_even(res8);
        end
    end

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ebc_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    case (ebc_pkg::cmd_t'(s_command))
                        ebc_pkg::CMD_EXEC: state_next = ebc_pkg::ST_OP;
                        ebc_pkg::CMD_READ: state_next = ebc_pkg::ST_RDWAIT;
                        default: state_next = ebc_pkg::ST_DONE;
                    endcase
                end
            end
            ebc_pkg::ST_RDWAIT: state_next = ebc_pkg::ST_DONE;
            ebc_pkg::ST_OP: begin
                if (need_imm1) begin
                    state_next = ebc_pkg::ST_IMM1;
                end else if (need_data1) begin
                    state_next = ebc_pkg::ST_DATA1;
                end else begin
                    state_next = ebc_pkg::ST_DONE;
                end
            end
            ebc_pkg::ST_IMM1: begin
                if (need_imm2) begin
                    state_next = ebc_pkg::ST_IMM2;
                end else begin
                    state_next = ebc_pkg::ST_DONE;
                end
            end
            ebc_pkg::ST_IMM2: begin
                if (need_data1) begin
                    state_next = ebc_pkg::ST_DATA1;
                end else if (wr2) begin
                    state_next = ebc_pkg::ST_WR2;
                end else begin
                    state_next = ebc_pkg::ST_DONE;
                end
            end
            ebc_pkg::ST_DATA1: begin
                if (need_data2) begin
                    state_next = ebc_pkg::ST_DATA2;
                end else begin
                    state_next = ebc_pkg::ST_DONE;
                end
            end
            ebc_pkg::ST_DATA2: state_next = ebc_pkg::ST_DONE;
            ebc_pkg::ST_WR2: state_next = ebc_pkg::ST_DONE;
            ebc_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = ebc_pkg::ST_IDLE;
                end
            end
            default: state_next = ebc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: memory port. The address issued in a state is read back in the next one.
    logic exec_now;
    always_comb begin
        mem_we = 1'b0;
        mem_a = pc_reg;
        mem_wd = wdat1;
        exec_now = 1'b0;
        case (state_reg)
            ebc_pkg::ST_IDLE: begin
                mem_a = (s_command == ebc_pkg::CMD_EXEC) ? pc_reg : s_address;
                mem_wd = s_data;
                mem_we = s_valid && s_ready && (s_command == ebc_pkg::CMD_LOAD);
            end
            ebc_pkg::ST_OP: begin
                if (need_imm1) begin
                    mem_a = pc_reg + 16'd1;
                end else if (need_data1) begin
                    mem_a = d1_addr;
                end else begin
                    mem_a = w1_addr;
                    mem_we = wr1;
                    exec_now = 1'b1;
                end
            end
            ebc_pkg::ST_IMM1: begin
                if (need_imm2) begin
                    mem_a = pc_reg + 16'd2;
                end else begin
                    mem_a = w1_addr;
                    mem_we = wr1;
                    exec_now = 1'b1;
                end
            end
            ebc_pkg::ST_IMM2: begin
                if (need_data1) begin
                    mem_a = imm16;
                end else begin
                    mem_a = imm16;
                    mem_we = wr1;
                    exec_now = !wr2;
                end
            end
            ebc_pkg::ST_DATA1: begin
                if (need_data2) begin
                    mem_a = d2_addr;
                end else begin
                    mem_a = w1_addr;
                    mem_we = wr1;
                    exec_now = 1'b1;
                end
            end
            ebc_pkg::ST_DATA2: exec_now = 1'b1;
            ebc_pkg::ST_WR2: begin
                mem_a = addr_reg + 16'd1;
                mem_wd = h_reg;
                mem_we = 1'b1;
                exec_now = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ebc_pkg::ST_IDLE;
            m_valid <= 1'b0;
            b_reg <= '0; c_reg <= '0; d_reg <= '0; e_reg <= '0;
            h_reg <= '0; l_reg <= '0; a_reg <= '0;
            pc_reg <= '0; sp_reg <= '0;
            fs_reg <= 1'b0; fz_reg <= 1'b0; fac_reg <= 1'b0; fp_reg <= 1'b0; fcy_reg <= 1'b0;
            rd_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            if (state_reg == ebc_pkg::ST_IDLE && s_valid && s_ready) begin
                rd_reg <= '0;
            end
            if (state_reg == ebc_pkg::ST_RDWAIT) begin
                rd_reg <= mem_rd;
            end
            if (exec_now) begin
                b_reg <= b_n; c_reg <= c_n; d_reg <= d_n; e_reg <= e_n;
                h_reg <= h_n; l_reg <= l_n; a_reg <= a_n;
                pc_reg <= pc_n; sp_reg <= sp_n;
                fs_reg <= fs_n; fz_reg <= fz_n; fac_reg <= fac_n;
                fp_reg <= fp_n; fcy_reg <= fcy_n;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ebc_pkg::ST_IDLE && s_valid && s_ready) begin
            cmd_reg <= s_command;
            addr_reg <= s_address;
            data_reg <= s_data;
        end
        if (state_reg == ebc_pkg::ST_OP) begin
            op_reg <= mem_rd;
        end
        if (state_reg == ebc_pkg::ST_IMM1) begin
            imm1_reg <= mem_rd;
        end
        if (state_reg == ebc_pkg::ST_IMM2) begin
            addr_reg <= imm16;
        end
        if (state_reg == ebc_pkg::ST_DATA1) begin
            data_reg <= mem_rd;
        end
        if (out_load) begin
            out_rd_reg <= rd_reg;
            out_pc_reg <= pc_reg;
            out_sp_reg <= sp_reg;
            out_a_reg <= a_reg;
            out_fl_reg <= {fs_reg, fz_reg, fac_reg, fp_reg, fcy_reg};
            out_bc_reg <= bc;
            out_de_reg <= de;
            out_hl_reg <= hl;
        end
    end

    assign m_read_data = out_rd_reg;
    assign m_program_counter = out_pc_reg;
    assign m_stack_pointer = out_sp_reg;
    assign m_accumulator = out_a_reg;
    assign m_flags = out_fl_reg;
    assign m_pair_bc = out_bc_reg;
    assign m_pair_de = out_de_reg;
    assign m_pair_hl = out_hl_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ebc_pkg::ST_IDLE) |-> !s_ready)
        else $error("input accepted while busy");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ebc_pkg::ST_DONE) |=> m_valid)
        else $error("result not presented after completion");
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ebc_pkg::ST_DONE && cmd_reg != ebc_pkg::CMD_READ) |-> (rd_reg == 8'h00))
        else $error("read data nonzero for non-read item");
    a_pc_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_program_counter))
        else $error("state changed while result pending");
endmodule

// ----- rtl/ebc_ram.sv -----
// Generic single-port RAM with registered read data.
module ebc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- dv/eight_bit_cpu_execute_unit_test.sv -----
// Self-checking testbench of the 8-bit execute unit with a built-in instruction predictor.
`timescale 1ns / 1ps
module eight_bit_cpu_execute_unit_test;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int QUIET_AFTER = 1100;
    localparam int R_B = 0, R_C = 1, R_D = 2, R_E = 3, R_H = 4, R_L = 5, R_A = 6;

    typedef struct packed {
        logic [7:0]  rd;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [7:0]  acc;
        logic [4:0]  fl;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
    } cpu_view_t;

    typedef struct {
        ebc_pkg::cmd_t cmd;
        logic [15:0]   addr;
        logic [7:0]    dat;
        bit            typed;
        cpu_view_t     view;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = ebc_pkg::CMD_NONE;
    logic [15:0] s_address = '0;
    logic [7:0]  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_read_data;
    logic [15:0] m_program_counter;
    logic [15:0] m_stack_pointer;
    logic [7:0]  m_accumulator;
    logic [4:0]  m_flags;
    logic [15:0] m_pair_bc;
    logic [15:0] m_pair_de;
    logic [15:0] m_pair_hl;

    eight_bit_cpu_execute_unit uut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    logic [7:0]  mem_img [0:65535];
    bit          mem_known [0:65535];
    logic [15:0] known_list [$];
    logic [7:0]  regs [0:6];
    logic [15:0] pc_q;
    logic [15:0] sp_q;
    logic        f_s, f_z, f_ac, f_p, f_cy;
    cpu_view_t   pending_views [$];
    logic [15:0] operand_addrs [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("eight_bit_cpu_execute_unit_test: done, errors");
            $finish;
        end
    end

    function automatic void mem_put(input logic [15:0] a, input logic [7:0] v);
        mem_img[a] = v;
        if (!mem_known[a]) begin
            mem_known[a] = 1'b1;
            known_list.push_back(a);
        end
    endfunction

    function automatic logic [15:0] hl_addr();
        return {regs[R_H], regs[R_L]};
    endfunction

    function automatic logic [7:0] reg_get(input logic [2:0] code);
        if (code == 3'd6) return mem_img[hl_addr()];
        if (code == 3'd7) return regs[R_A];
        return regs[code];
    endfunction

    function automatic void reg_put(input logic [2:0] code, input logic [7:0] v);
        if (code == 3'd6) mem_put(hl_addr(), v);
        else if (code == 3'd7) regs[R_A] = v;
        else regs[code] = v;
    endfunction

    function automatic logic [15:0] pair_get(input logic [1:0] p);
        if (p == 2'd3) return sp_q;
        return {regs[{p, 1'b0}], regs[{p, 1'b1}]};
    endfunction

    function automatic void pair_put(input logic [1:0] p, input logic [15:0] v);
        if (p == 2'd3) begin
            sp_q = v;
        end else begin
            regs[{p, 1'b0}] = v[15:8];
            regs[{p, 1'b1}] = v[7:0];
        end
    endfunction

    function automatic void set_szp(input logic [7:0] v);
        f_s = v[7];
        f_z = (v == 8'd0);
        f_p = ~^v;
    endfunction

    function automatic logic [7:0] add_byte(input logic [7:0] a, input logic [7:0] b,
                                            input logic cin, output logic co);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        f_ac = a[4] ^ b[4] ^ s[4];
        co = s[8];
        set_szp(s[7:0]);
        return s[7:0];
    endfunction

    function automatic void alu_op(input logic [2:0] op, input logic [7:0] x);
        logic [7:0] a;
        logic [7:0] r;
        logic c;
        a = regs[R_A];
        case (op)
            3'd0: begin regs[R_A] = add_byte(a, x, 1'b0, c); f_cy = c; end
            3'd1: begin regs[R_A] = add_byte(a, x, f_cy, c); f_cy = c; end
            3'd2: begin regs[R_A] = add_byte(a, ~x, 1'b1, c); f_cy = !c; end
            3'd3: begin regs[R_A] = add_byte(a, ~x, !f_cy, c); f_cy = !c; end
            3'd4: begin
                r = a & x; f_cy = 1'b0; f_ac = a[3] | x[3];
                set_szp(r); regs[R_A] = r;
            end
            3'd5: begin
                r = a ^ x; f_cy = 1'b0; f_ac = 1'b0;
                set_szp(r); regs[R_A] = r;
            end
            3'd6: begin
                r = a | x; f_cy = 1'b0; f_ac = 1'b0;
                set_szp(r); regs[R_A] = r;
            end
            default: begin r = add_byte(a, ~x, 1'b1, c); f_cy = !c; end
        endcase
    endfunction

    function automatic void run_opcode();
        logic [15:0] pc0, p1, p2, imm16, t;
        logic [7:0]  op, imm8, v, a, corr;
        logic [2:0]  y;
        logic [16:0] s17;
        logic [3:0]  lo, hi;
        logic        c, cy;
        int          len;
        pc0 = pc_q;
        p1 = pc0 + 16'd1;
        p2 = pc0 + 16'd2;
        op = mem_img[pc0];
        imm8 = mem_img[p1];
        imm16 = {mem_img[p2], imm8};
        len = 1;
        y = op[5:3];
        if (op >= 8'h40 && op <= 8'h7f) begin
            if (op != ebc_pkg::OP_HLT) reg_put(y, reg_get(op[2:0]));
        end else if (op >= 8'h80 && op <= 8'hbf) begin
            alu_op(y, reg_get(op[2:0]));
        end else if (op == ebc_pkg::OP_RNZ) begin
            if (!f_z) begin
                t = sp_q + 16'd1;
                pc_q = {mem_img[t], mem_img[sp_q]};
                sp_q = sp_q + 16'd2;
                return;
            end
        end else if (op == ebc_pkg::OP_POP_B) begin
            t = sp_q + 16'd1;
            regs[R_C] = mem_img[sp_q];
            regs[R_B] = mem_img[t];
            sp_q = sp_q + 16'd2;
        end else if (op < 8'h40) begin
            case (op[2:0])
                3'd1: begin
                    if (y[0]) begin
                        s17 = {1'b0, pair_get(2'd2)} + {1'b0, pair_get(y[2:1])};
                        f_cy = s17[16];
                        pair_put(2'd2, s17[15:0]);
                    end else begin
                        pair_put(y[2:1], imm16); len = 3;
                    end
                end
                3'd2: begin
                    t = imm16 + 16'd1;
                    case (y)
                        3'd0: mem_put(pair_get(2'd0), regs[R_A]);
                        3'd1: regs[R_A] = mem_img[pair_get(2'd0)];
                        3'd2: mem_put(pair_get(2'd1), regs[R_A]);
                        3'd3: regs[R_A] = mem_img[pair_get(2'd1)];
                        3'd4: begin
                            mem_put(imm16, regs[R_L]); mem_put(t, regs[R_H]); len = 3;
                        end
                        3'd5: begin
                            regs[R_L] = mem_img[imm16]; regs[R_H] = mem_img[t]; len = 3;
                        end
                        3'd6: begin mem_put(imm16, regs[R_A]); len = 3; end
                        default: begin regs[R_A] = mem_img[imm16]; len = 3; end
                    endcase
                end
                3'd3: begin
                    if (y[0]) pair_put(y[2:1], pair_get(y[2:1]) - 16'd1);
                    else pair_put(y[2:1], pair_get(y[2:1]) + 16'd1);
                end
                3'd4: begin
                    v = reg_get(y); f_ac = (v[3:0] == 4'hf);
                    v = v + 8'd1; set_szp(v); reg_put(y, v);
                end
                3'd5: begin
                    v = reg_get(y); f_ac = (v[3:0] != 4'h0);
                    v = v - 8'd1; set_szp(v); reg_put(y, v);
                end
                3'd6: begin reg_put(y, imm8); len = 2; end
                3'd7: begin
                    a = regs[R_A];
                    case (y)
                        3'd0: begin f_cy = a[7]; a = {a[6:0], a[7]}; end
                        3'd1: begin f_cy = a[0]; a = {a[0], a[7:1]}; end
                        3'd2: begin c = f_cy; f_cy = a[7]; a = {a[6:0], c}; end
                        3'd3: begin c = f_cy; f_cy = a[0]; a = {c, a[7:1]}; end
                        3'd4: begin
                            lo = a[3:0]; hi = a[7:4]; corr = 8'h00; cy = f_cy;
                            if (lo > 4'd9 || f_ac) corr = corr + 8'h06;
                            if (hi > 4'd9 || f_cy || (hi >= 4'd9 && lo > 4'd9)) begin
                                corr = corr + 8'h60; cy = 1'b1;
                            end
                            a = add_byte(a, corr, 1'b0, c);
                            f_cy = cy;
                        end
                        3'd5: a = ~a;
                        3'd6: f_cy = 1'b1;
                        default: f_cy = !f_cy;
                    endcase
                    regs[R_A] = a;
                end
                default: ;
            endcase
        end
        pc_q = pc0 + len[15:0];
    endfunction

    function automatic cpu_view_t cpu_step(input ebc_pkg::cmd_t cmd, input logic [15:0] addr,
                                           input logic [7:0] dat);
        cpu_view_t v;
        v.rd = 8'd0;
        case (cmd)
            ebc_pkg::CMD_LOAD: mem_put(addr, dat);
            ebc_pkg::CMD_EXEC: run_opcode();
            ebc_pkg::CMD_READ: v.rd = mem_img[addr];
            default: ;
        endcase
        v.pc = pc_q;
        v.sp = sp_q;
        v.acc = regs[R_A];
        v.fl = {f_s, f_z, f_ac, f_p, f_cy};
        v.bc = pair_get(2'd0);
        v.de = pair_get(2'd1);
        v.hl = pair_get(2'd2);
        return v;
    endfunction

    // Addresses that the instruction at pc reads besides its own three bytes.
    function automatic void collect_operands();
        logic [7:0]  op;
        logic [2:0]  y;
        logic [15:0] imm16;
        op = mem_img[pc_q];
        y = op[5:3];
        imm16 = {mem_img[pc_q + 16'd2], mem_img[pc_q + 16'd1]};
        operand_addrs.delete();
        if (op < 8'hc0 && op >= 8'h40 && op != ebc_pkg::OP_HLT && op[2:0] == 3'd6)
            operand_addrs.push_back(hl_addr());
        else if (op == ebc_pkg::OP_POP_B || (op == ebc_pkg::OP_RNZ && !f_z)) begin
            operand_addrs.push_back(sp_q);
            operand_addrs.push_back(sp_q + 16'd1);
        end else if (op < 8'h40) begin
            if (op[2:0] == 3'd2) begin
                case (y)
                    3'd1: operand_addrs.push_back(pair_get(2'd0));
                    3'd3: operand_addrs.push_back(pair_get(2'd1));
                    3'd5: begin
                        operand_addrs.push_back(imm16);
                        operand_addrs.push_back(imm16 + 16'd1);
                    end
                    3'd7: operand_addrs.push_back(imm16);
                    default: ;
                endcase
            end else if ((op[2:0] == 3'd4 || op[2:0] == 3'd5) && y == 3'd6) begin
                operand_addrs.push_back(hl_addr());
            end
        end
    endfunction

    task automatic send(input ebc_pkg::cmd_t cmd, input logic [15:0] addr,
                        input logic [7:0] dat, input bit typed, input cpu_view_t tv);
        bit taken;
        cpu_view_t pv;
        s_valid <= 1'b1;
        s_command <= cmd;
        s_address <= addr;
        s_data <= dat;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        pv = cpu_step(cmd, addr, dat);
        pending_views.push_back(typed ? tv : pv);
        items_sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic send_plain(input ebc_pkg::cmd_t cmd, input logic [15:0] addr,
                              input logic [7:0] dat);
        send(cmd, addr, dat, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    initial begin
        cpu_view_t w;
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (m_valid && m_ready) begin
                if (pending_views.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result item with nothing expected");
                end else begin
                    w = pending_views.pop_front();
                    check_field("read_data", 16'(w.rd), 16'(m_read_data));
                    check_field("program_counter", w.pc, m_program_counter);
                    check_field("stack_pointer", w.sp, m_stack_pointer);
                    check_field("accumulator", 16'(w.acc), 16'(m_accumulator));
                    check_field("flags", 16'(w.fl), 16'(m_flags));
                    check_field("pair_bc", w.bc, m_pair_bc);
                    check_field("pair_de", w.de, m_pair_de);
                    check_field("pair_hl", w.hl, m_pair_hl);
                end
            end
            @(posedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 19) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // The step that runs ADD A (8'h87) with A at 8'hff gives FE with S, AC and CY set.
    stim_row_t directed [] = '{
        '{ebc_pkg::CMD_NONE, 16'h1234, 8'h5a, 1'b1, '0},
        '{ebc_pkg::CMD_LOAD, 16'h0000, 8'h3e, 1'b0, '0},
        '{ebc_pkg::CMD_LOAD, 16'h0001, 8'hff, 1'b0, '0},
        '{ebc_pkg::CMD_LOAD, 16'h0002, 8'h87, 1'b0, '0},
        '{ebc_pkg::CMD_LOAD, 16'h0003, ebc_pkg::OP_HLT, 1'b0, '0},
        '{ebc_pkg::CMD_LOAD, 16'h0004, 8'h97, 1'b0, '0},
        '{ebc_pkg::CMD_LOAD, 16'h0005, 8'hc2, 1'b0, '0},
        '{ebc_pkg::CMD_LOAD, 16'h0006, 8'h27, 1'b0, '0},
        '{ebc_pkg::CMD_LOAD, 16'h0007, 8'h00, 1'b0, '0},
        '{ebc_pkg::CMD_LOAD, 16'h0008, 8'h00, 1'b0, '0},
        '{ebc_pkg::CMD_LOAD, 16'hffff, 8'h80, 1'b0, '0},
        '{ebc_pkg::CMD_READ, 16'hffff, 8'h00, 1'b1,
          cpu_view_t'{8'h80, 16'h0, 16'h0, 8'h0, 5'h0, 16'h0, 16'h0, 16'h0}},
        '{ebc_pkg::CMD_READ, 16'h0001, 8'h00, 1'b1,
          cpu_view_t'{8'hff, 16'h0, 16'h0, 8'h0, 5'h0, 16'h0, 16'h0, 16'h0}},
        '{ebc_pkg::CMD_EXEC, 16'h0000, 8'h00, 1'b1,
          cpu_view_t'{8'h00, 16'h2, 16'h0, 8'hff, 5'h00, 16'h0, 16'h0, 16'h0}},
        '{ebc_pkg::CMD_EXEC, 16'h0000, 8'h00, 1'b1,
          cpu_view_t'{8'h00, 16'h3, 16'h0, 8'hfe, 5'h15, 16'h0, 16'h0, 16'h0}},
        '{ebc_pkg::CMD_EXEC, 16'hffff, 8'hff, 1'b0, '0},
        '{ebc_pkg::CMD_EXEC, 16'h0000, 8'h00, 1'b0, '0},
        '{ebc_pkg::CMD_EXEC, 16'h0000, 8'h00, 1'b0, '0},
        '{ebc_pkg::CMD_EXEC, 16'h0000, 8'h00, 1'b0, '0},
        '{ebc_pkg::CMD_NONE, 16'hffff, 8'hff, 1'b0, '0}
    };

    initial begin
        logic [15:0] a;
        logic [7:0]  op;
        int pick;
        foreach (mem_known[i]) mem_known[i] = 1'b0;
        foreach (regs[i]) regs[i] = 8'd0;
        pc_q = '0;
        sp_q = '0;
        {f_s, f_z, f_ac, f_p, f_cy} = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send(directed[i].cmd, directed[i].addr, directed[i].dat, directed[i].typed,
                 directed[i].view);

        while (items_sent < RANDOM_ITEMS) begin
            quiet = (items_sent > QUIET_AFTER);
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                case ($urandom_range(0, 19))
                    0: op = 8'($urandom_range(8'hc2, 8'hff));
                    1: op = ebc_pkg::OP_HLT;
                    default: op = 8'($urandom_range(8'h00, 8'hc1));
                endcase
                send_plain(ebc_pkg::CMD_LOAD, pc_q, op);
                for (int k = 1; k <= 2; k++) begin
                    a = pc_q + 16'(k);
                    if (!mem_known[a] || $urandom_range(0, 1))
                        send_plain(ebc_pkg::CMD_LOAD, a, 8'($urandom));
                end
                collect_operands();
                foreach (operand_addrs[k])
                    if (!mem_known[operand_addrs[k]])
                        send_plain(ebc_pkg::CMD_LOAD, operand_addrs[k], 8'($urandom));
                send_plain(ebc_pkg::CMD_EXEC, 16'($urandom), 8'($urandom));
            end else if (pick < 82) begin
                send_plain(ebc_pkg::CMD_LOAD, 16'($urandom), 8'($urandom));
            end else if (pick < 94) begin
                a = known_list[$urandom_range(0, known_list.size() - 1)];
                send_plain(ebc_pkg::CMD_READ, a, 8'($urandom));
            end else begin
                send_plain(ebc_pkg::CMD_NONE, 16'($urandom), 8'($urandom));
            end
        end
        s_valid <= 1'b0;

        while (pending_views.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("eight_bit_cpu_execute_unit_test: done, clean");
        else
            $display("eight_bit_cpu_execute_unit_test: done, errors");
        $finish;
    end
endmodule
